>>> rtl/core/ieba_pkg.sv
package ieba_pkg;

  // request kinds after decode of the action field
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // raw action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // reset bus address of the eeprom
  localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

  // bits per byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // bus sequencer phases
  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000000000000001,
    PH_PRE_WP  = 15'b000000000000010,
    PH_PRE_SDA = 15'b000000000000100,
    PH_PRE_SCL = 15'b000000000001000,
    PH_START   = 15'b000000000010000,
    PH_DEV_W   = 15'b000000000100000,
    PH_WORD    = 15'b000000001000000,
    PH_DATA    = 15'b000000010000000,
    PH_START_R = 15'b000000100000000,
    PH_DEV_R   = 15'b000001000000000,
    PH_RELEASE = 15'b000010000000000,
    PH_READ    = 15'b000100000000000,
    PH_NACK    = 15'b001000000000000,
    PH_STOP    = 15'b010000000000000,
    PH_WP_HIGH = 15'b100000000000000
  } phase_t;

  // classified request between front and back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  word_address;
    logic [7:0]  write_data;
    logic        sda_in;
  } req_t;

  // one result of a tick
  typedef struct packed {
    logic        scl_level;
    logic        sda_release;
    logic        write_protect;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_byte;
  } res_t;

endpackage

>>> rtl/core/ieba_front.sv
module ieba_front
  import ieba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action,
  input  logic [7:0] word_address,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  output logic       req_valid,
  output req_t       req,
  input  logic       req_take
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  req_t       in_req;

  // decode the action into a request kind
  always_comb begin
    in_req.word_address = word_address;
    in_req.write_data   = write_data;
    in_req.sda_in       = sda_in;
    case (action)
      ACT_WRITE: in_req.kind = KIND_WRITE;
      ACT_READ:  in_req.kind = KIND_READ;
      default:   in_req.kind = KIND_TICK;
    endcase
  end

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign req_valid = (count != 2'd0);
  assign req       = slots[rd_ptr];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (req_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, req_take};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_req;
    end
  end

endmodule

>>> rtl/core/ieba_seq.sv
module ieba_seq
  import ieba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       config_write,
  input  logic [6:0] config_data,
  input  logic       req_valid,
  input  req_t       req,
  output logic       req_take,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res
);

  logic [6:0] device_address;
  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [1:0] sub_step, sub_step_next;
  logic [7:0] shift_register, shift_register_next;
  logic       is_read, is_read_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_data, held_data_next;
  logic [7:0] last_read, last_read_next;
  logic       scl, scl_next;
  logic       sda, sda_next;
  logic       wp, wp_next;

  phase_t     cur_ph;
  phase_t     enter_ph;
  logic       do_enter;
  logic       busy;
  logic       done;
  logic [7:0] sampled;
  logic [3:0] bc_inc;

  assign req_take = req_valid && !res_full;
  assign res_push = req_take;

  // one line change per tick
  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    sub_step_next       = sub_step;
    shift_register_next = shift_register;
    is_read_next        = is_read;
    held_address_next   = held_address;
    held_data_next      = held_data;
    last_read_next      = last_read;
    scl_next            = scl;
    sda_next            = sda;
    wp_next             = wp;
    cur_ph              = phase;
    enter_ph            = PH_IDLE;
    do_enter            = 1'b0;
    busy                = 1'b0;
    done                = 1'b0;
    sampled             = {shift_register[6:0], req.sda_in};
    bc_inc              = bit_count + 4'd1;

    // new request only when idle
    if (phase == PH_IDLE && (req.kind == KIND_WRITE || req.kind == KIND_READ)) begin
      held_address_next = req.word_address;
      held_data_next    = req.write_data;
      is_read_next      = (req.kind == KIND_READ);
      cur_ph            = (req.kind == KIND_READ) ? PH_PRE_SDA : PH_PRE_WP;
      bit_count_next    = 4'd0;
      sub_step_next     = 2'd0;
      phase_next        = cur_ph;
    end

    if (cur_ph != PH_IDLE) begin
      busy = 1'b1;
      unique case (cur_ph)
        PH_PRE_WP: begin
          wp_next  = 1'b0;
          do_enter = 1'b1;
          enter_ph = PH_PRE_SDA;
        end
        PH_PRE_SDA: begin
          sda_next = 1'b1;
          do_enter = 1'b1;
          enter_ph = PH_PRE_SCL;
        end
        PH_PRE_SCL: begin
          scl_next = 1'b0;
          do_enter = 1'b1;
          enter_ph = PH_START;
        end
        PH_START, PH_START_R: begin
          case (sub_step)
            2'd0:    sda_next = 1'b1;
            2'd1:    scl_next = 1'b1;
            2'd2:    sda_next = 1'b0;
            default: scl_next = 1'b0;
          endcase
          if (sub_step != 2'd3) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            do_enter = 1'b1;
            enter_ph = (cur_ph == PH_START) ? PH_DEV_W : PH_DEV_R;
          end
        end
        PH_DEV_W, PH_WORD, PH_DATA, PH_DEV_R: begin
          case (sub_step)
            2'd0: begin
              sda_next      = bit_count[3] ? 1'b1 : shift_register[7];
              sub_step_next = 2'd1;
            end
            2'd1: begin
              scl_next      = 1'b1;
              sub_step_next = 2'd2;
            end
            default: begin
              scl_next = 1'b0;
              if (!bit_count[3]) begin
                shift_register_next = {shift_register[6:0], 1'b0};
                bit_count_next      = bc_inc;
                sub_step_next       = 2'd0;
              end else begin
                // byte and ack clock finished
                do_enter = 1'b1;
                if (cur_ph == PH_DEV_W) begin
                  enter_ph = PH_WORD;
                end else if (cur_ph == PH_WORD) begin
                  enter_ph = is_read ? PH_START_R : PH_DATA;
                end else if (cur_ph == PH_DATA) begin
                  enter_ph = PH_STOP;
                end else begin
                  enter_ph = PH_RELEASE;
                end
              end
            end
          endcase
        end
        PH_RELEASE: begin
          sda_next = 1'b1;
          do_enter = 1'b1;
          enter_ph = PH_READ;
        end
        PH_READ: begin
          if (sub_step == 2'd0) begin
            scl_next      = 1'b1;
            sub_step_next = 2'd1;
          end else begin
            // sample while scl is still high
            shift_register_next = sampled;
            scl_next            = 1'b0;
            bit_count_next      = bc_inc;
            sub_step_next       = 2'd0;
            if (bc_inc >= BYTE_BITS) begin
              last_read_next = sampled;
              do_enter       = 1'b1;
              enter_ph       = PH_NACK;
            end
          end
        end
        PH_NACK: begin
          case (sub_step)
            2'd0:    sda_next = 1'b1;
            2'd1:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            do_enter = 1'b1;
            enter_ph = PH_STOP;
          end
        end
        PH_STOP: begin
          case (sub_step)
            2'd0:    sda_next = 1'b0;
            2'd1:    scl_next = 1'b1;
            default: sda_next = 1'b1;
          endcase
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else if (is_read) begin
            do_enter = 1'b1;
            enter_ph = PH_IDLE;
            done     = 1'b1;
          end else begin
            do_enter = 1'b1;
            enter_ph = PH_WP_HIGH;
          end
        end
        PH_WP_HIGH: begin
          wp_next  = 1'b1;
          do_enter = 1'b1;
          enter_ph = PH_IDLE;
          done     = 1'b1;
        end
        default: begin
          do_enter = 1'b1;
          enter_ph = PH_IDLE;
        end
      endcase
    end

    // phase entry clears counters and loads the byte to send
    if (do_enter) begin
      phase_next     = enter_ph;
      bit_count_next = 4'd0;
      sub_step_next  = 2'd0;
      if (enter_ph == PH_DEV_W) begin
        shift_register_next = {device_address, 1'b0};
      end else if (enter_ph == PH_DEV_R) begin
        shift_register_next = {device_address, 1'b1};
      end else if (enter_ph == PH_WORD) begin
        shift_register_next = held_address;
      end else if (enter_ph == PH_DATA) begin
        shift_register_next = held_data;
      end
    end
  end

  // result of this tick
  always_comb begin
    res.scl_level     = scl_next;
    res.sda_release   = sda_next;
    res.write_protect = wp_next;
    res.busy_res      = busy;
    res.done_res      = done;
    res.read_byte     = last_read_next;
  end

  // address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
    end else if (config_write) begin
      device_address <= config_data;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= 4'd0;
      sub_step       <= 2'd0;
      shift_register <= 8'd0;
      is_read        <= 1'b0;
      held_address   <= 8'd0;
      held_data      <= 8'd0;
      last_read      <= 8'd0;
      scl            <= 1'b1;
      sda            <= 1'b1;
      wp             <= 1'b1;
    end else if (req_take) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      sub_step       <= sub_step_next;
      shift_register <= shift_register_next;
      is_read        <= is_read_next;
      held_address   <= held_address_next;
      held_data      <= held_data_next;
      last_read      <= last_read_next;
      scl            <= scl_next;
      sda            <= sda_next;
      wp             <= wp_next;
    end
  end

endmodule

>>> rtl/core/ieba_out_fifo.sv
module ieba_out_fifo
  import ieba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_in,
  output logic res_full,
  output logic empty,
  input  logic pop,
  output res_t res_out
);

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_pop   = pop && !empty;
  assign res_out  = slots[rd_ptr];

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, res_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res_in;
    end
  end

endmodule

>>> rtl/core/i2c_eeprom_byte_access_master_top.sv
// I2C byte write / random read master for a serial EEPROM, one bus line
// change per tick request.
// Input channel: push with action, word_address, write_data, sda_in; the
// request is taken on a clock edge with push high and full low. Action 1
// starts a byte write, 2 a random read, anything else is a plain tick;
// start requests are ignored while a transfer runs.
// Result channel: one result per request, shown while empty is low and taken
// on a clock edge with pop high; it carries the scl, sda and write-protect
// levels after the tick, busy_res, done_res and the last byte read.
// Config: config_write with config_data sets the 7-bit device address
// (reset 80); write it only while no request or result is in flight.
// Path: a taken request is registered in the request queue, then passes the
// bus sequencer into the result queue, from which it can be popped; a full
// result queue holds it in the request queue. Throughput: one request per
// cycle while the result queue has room, one sequencer step per request.
// Reset: both queues empty, sequencer idle, all bus lines high.
// When pop stays low the result queue fills, the sequencer holds, then the
// request queue fills and full rises; nothing is lost.
module i2c_eeprom_byte_access_master_top
  import ieba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action,
  input  logic [7:0] word_address,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  output logic       empty,
  input  logic       pop,
  output logic       scl_level,
  output logic       sda_release,
  output logic       write_protect,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_byte,
  input  logic       config_write,
  input  logic [6:0] config_data
);

  logic req_valid;
  req_t req;
  logic req_take;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  // request decode and queue
  ieba_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .word_address (word_address),
    .write_data   (write_data),
    .sda_in       (sda_in),
    .req_valid    (req_valid),
    .req          (req),
    .req_take     (req_take)
  );

  // bus sequencer
  ieba_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_data  (config_data),
    .req_valid    (req_valid),
    .req          (req),
    .req_take     (req_take),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res_in)
  );

  // result queue
  ieba_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign scl_level     = res_out.scl_level;
  assign sda_release   = res_out.sda_release;
  assign write_protect = res_out.write_protect;
  assign busy_res      = res_out.busy_res;
  assign done_res      = res_out.done_res;
  assign read_byte     = res_out.read_byte;

endmodule

>>> bench/eeprom_bus_checker.sv
module eeprom_bus_checker
  import ieba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] action,
  input  logic [7:0] word_address,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  input  logic       empty,
  input  logic       pop,
  input  logic       scl_level,
  input  logic       sda_release,
  input  logic       write_protect,
  input  logic       busy_res,
  input  logic       done_res,
  input  logic [7:0] read_byte,
  input  logic       config_write,
  input  logic [6:0] config_data,
  output int         error_count,
  output int         pending,
  output int         checked,
  output logic       bus_idle
);

  // shadow copy of the sequencer
  phase_t     seq_phase;
  logic [3:0] bit_cnt;
  logic [1:0] step_cnt;
  logic [7:0] shift_q;
  logic       read_mode;
  logic [7:0] addr_q;
  logic [7:0] data_q;
  logic [7:0] last_byte;
  logic       scl_q;
  logic       sda_q;
  logic       wp_q;
  logic [6:0] dev_addr;

  // line levels expected for each accepted request, oldest first
  res_t line_results_q[$];

  assign bus_idle = (seq_phase == PH_IDLE);

  // move to a phase and load the byte it sends
  task automatic load_phase(input phase_t p);
    seq_phase = p;
    bit_cnt = '0;
    step_cnt = '0;
    case (p)
      PH_DEV_W: shift_q = {dev_addr, 1'b0};
      PH_DEV_R: shift_q = {dev_addr, 1'b1};
      PH_WORD:  shift_q = addr_q;
      PH_DATA:  shift_q = data_q;
      default:  ;
    endcase
  endtask

  // one tick: apply a single line change and report the line state
  task automatic predict_tick(input logic [1:0] act, input logic [7:0] wa,
                              input logic [7:0] wd, input logic sda,
                              output res_t r);
    logic busy;
    logic fin;
    busy = 1'b0;
    fin = 1'b0;
    if (seq_phase == PH_IDLE && (act == ACT_WRITE || act == ACT_READ)) begin
      addr_q = wa;
      data_q = wd;
      read_mode = (act == ACT_READ);
      load_phase(read_mode ? PH_PRE_SDA : PH_PRE_WP);
    end
    if (seq_phase != PH_IDLE) begin
      busy = 1'b1;
      case (seq_phase)
        PH_PRE_WP: begin
          wp_q = 1'b0;
          load_phase(PH_PRE_SDA);
        end
        PH_PRE_SDA: begin
          sda_q = 1'b1;
          load_phase(PH_PRE_SCL);
        end
        PH_PRE_SCL: begin
          scl_q = 1'b0;
          load_phase(PH_START);
        end
        // start and repeated start
        PH_START, PH_START_R: begin
          case (step_cnt)
            2'd0: sda_q = 1'b1;
            2'd1: scl_q = 1'b1;
            2'd2: sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
          if (step_cnt < 2'd3) step_cnt++;
          else load_phase(seq_phase == PH_START ? PH_DEV_W : PH_DEV_R);
        end
        // eight data bits then a released ack clock
        PH_DEV_W, PH_WORD, PH_DATA, PH_DEV_R: begin
          if (step_cnt == 2'd0) begin
            sda_q = (bit_cnt < BYTE_BITS) ? shift_q[7] : 1'b1;
            step_cnt = 2'd1;
          end else if (step_cnt == 2'd1) begin
            scl_q = 1'b1;
            step_cnt = 2'd2;
          end else begin
            scl_q = 1'b0;
            if (bit_cnt < BYTE_BITS) begin
              shift_q = shift_q << 1;
              bit_cnt++;
              step_cnt = 2'd0;
            end else begin
              case (seq_phase)
                PH_DEV_W: load_phase(PH_WORD);
                PH_WORD:  load_phase(read_mode ? PH_START_R : PH_DATA);
                PH_DATA:  load_phase(PH_STOP);
                default:  load_phase(PH_RELEASE);
              endcase
            end
          end
        end
        PH_RELEASE: begin
          sda_q = 1'b1;
          load_phase(PH_READ);
        end
        // sample on the falling scl tick, while scl is still high
        PH_READ: begin
          if (step_cnt == 2'd0) begin
            scl_q = 1'b1;
            step_cnt = 2'd1;
          end else begin
            shift_q = {shift_q[6:0], sda};
            scl_q = 1'b0;
            bit_cnt++;
            step_cnt = 2'd0;
            if (bit_cnt >= BYTE_BITS) begin
              last_byte = shift_q;
              load_phase(PH_NACK);
            end
          end
        end
        PH_NACK: begin
          case (step_cnt)
            2'd0: sda_q = 1'b1;
            2'd1: scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
          if (step_cnt < 2'd2) step_cnt++;
          else load_phase(PH_STOP);
        end
        PH_STOP: begin
          case (step_cnt)
            2'd0: sda_q = 1'b0;
            2'd1: scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
          if (step_cnt < 2'd2) begin
            step_cnt++;
          end else if (read_mode) begin
            load_phase(PH_IDLE);
            fin = 1'b1;
          end else begin
            load_phase(PH_WP_HIGH);
          end
        end
        PH_WP_HIGH: begin
          wp_q = 1'b1;
          load_phase(PH_IDLE);
          fin = 1'b1;
        end
        default: load_phase(PH_IDLE);
      endcase
    end
    r.scl_level = scl_q;
    r.sda_release = sda_q;
    r.write_protect = wp_q;
    r.busy_res = busy;
    r.done_res = fin;
    r.read_byte = last_byte;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // track requests, config writes and results at each rising edge
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      seq_phase = PH_IDLE;
      bit_cnt = '0;
      step_cnt = '0;
      shift_q = '0;
      read_mode = 1'b0;
      addr_q = '0;
      data_q = '0;
      last_byte = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      wp_q = 1'b1;
      dev_addr = DEV_ADDR_RESET;
      line_results_q.delete();
      error_count = 0;
      checked = 0;
    end else begin
      if (config_write) dev_addr = config_data;
      if (push && !full) begin
        predict_tick(action, word_address, write_data, sda_in, want);
        line_results_q.push_back(want);
      end
      if (pop && !empty) begin
        if (line_results_q.size() == 0) begin
          $error("result popped with no request outstanding");
          error_count++;
        end else begin
          want = line_results_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(scl_level));
          check_field("sda_release", 8'(want.sda_release), 8'(sda_release));
          check_field("write_protect", 8'(want.write_protect), 8'(write_protect));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
          check_field("done_res", 8'(want.done_res), 8'(done_res));
          check_field("read_byte", want.read_byte, read_byte);
          checked++;
        end
      end
    end
    pending = line_results_q.size();
  end

endmodule

>>> bench/tb_i2c_eeprom_byte_access_master_top.sv
module tb_i2c_eeprom_byte_access_master_top;
  import ieba_pkg::*;

  // action value with no meaning, behaves as a plain tick
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] action;
  logic [7:0] word_address;
  logic [7:0] write_data;
  logic       sda_in;
  logic       empty;
  logic       pop;
  logic       scl_level;
  logic       sda_release;
  logic       write_protect;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       config_write;
  logic [6:0] config_data;

  int   error_count;
  int   pending;
  int   checked;
  logic bus_idle;

  int   sent = 0;
  int   writes = 0;
  int   reads = 0;
  int   settings = 0;
  int   tx_steady = 0;
  int   quiet_cycles = 0;
  logic hold_pop = 1'b0;

  i2c_eeprom_byte_access_master_top dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .word_address  (word_address),
    .write_data    (write_data),
    .sda_in        (sda_in),
    .empty         (empty),
    .pop           (pop),
    .scl_level     (scl_level),
    .sda_release   (sda_release),
    .write_protect (write_protect),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .read_byte     (read_byte),
    .config_write  (config_write),
    .config_data   (config_data)
  );

  eeprom_bus_checker chk (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .word_address  (word_address),
    .write_data    (write_data),
    .sda_in        (sda_in),
    .empty         (empty),
    .pop           (pop),
    .scl_level     (scl_level),
    .sda_release   (sda_release),
    .write_protect (write_protect),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .read_byte     (read_byte),
    .config_write  (config_write),
    .config_data   (config_data),
    .error_count   (error_count),
    .pending       (pending),
    .checked       (checked),
    .bus_idle      (bus_idle)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random pops, short and long stalls, one long hold-off
  initial begin
    int gap;
    int steady;
    int r;
    gap = 0;
    steady = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pop = 1'b0;
      end else if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
        if (steady > 0) begin
          steady--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) steady = $urandom_range(30, 80);
          else if (r < 27) gap = $urandom_range(1, 3);
          else if (r < 31) gap = $urandom_range(10, 40);
        end
      end
    end
  end

  // offer one request; caller is already at a falling edge
  task automatic drive_tick(input logic [1:0] act, input logic [7:0] wa,
                            input logic [7:0] wd, input logic sda);
    if (bus_idle && act == ACT_WRITE) writes++;
    if (bus_idle && act == ACT_READ) reads++;
    push <= 1'b1;
    action <= act;
    word_address <= wa;
    write_data <= wd;
    sda_in <= sda;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // mostly back to back, some short gaps, a few long ones
  task automatic sender_gap();
    int r;
    if (tx_steady > 0) begin
      tx_steady--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) tx_steady = $urandom_range(30, 80);
      else if (r < 25) pause_sender($urandom_range(1, 3));
      else if (r < 29) pause_sender($urandom_range(10, 40));
    end
  endtask

  // idle bus: mostly start a transfer; busy bus: any action, requests ignored
  task automatic random_tick();
    logic [1:0] act;
    @(negedge clk);
    if (!bus_idle) act = 2'($urandom_range(0, 3));
    else if ($urandom_range(0, 9) < 8) act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
    else act = $urandom_range(0, 1) ? ACT_TICK : ACT_SPARE;
    drive_tick(act, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    sender_gap();
  endtask

  // keep ticking until the running transfer has finished
  task automatic run_to_idle(input logic sda_rand, input logic sda_level);
    logic finished;
    logic sda;
    finished = 1'b0;
    while (!finished) begin
      @(negedge clk);
      if (bus_idle) begin
        push <= 1'b0;
        finished = 1'b1;
      end else begin
        sda = sda_rand ? 1'($urandom_range(0, 1)) : sda_level;
        drive_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), sda);
        sender_gap();
      end
    end
  endtask

  // wait for every result, then for the pipeline to settle
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // address change only with the bus idle and nothing in flight
  task automatic set_address(input logic [6:0] addr);
    drain();
    @(negedge clk);
    config_write <= 1'b1;
    config_data <= addr;
    @(negedge clk);
    config_write <= 1'b0;
    settings++;
  endtask

  // stimulus and verdict
  initial begin
    logic [6:0] addr_plan [3];
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    action = ACT_TICK;
    word_address = '0;
    write_data = '0;
    sda_in = 1'b0;
    config_write = 1'b0;
    config_data = '0;
    addr_plan[0] = 7'd0;
    addr_plan[1] = 7'd127;
    addr_plan[2] = 7'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle ticks, spare action, write and read at the extremes
    @(negedge clk);
    drive_tick(ACT_TICK, 8'h00, 8'h00, 1'b0);
    @(negedge clk);
    drive_tick(ACT_SPARE, 8'hFF, 8'hFF, 1'b1);
    @(negedge clk);
    drive_tick(ACT_WRITE, 8'h00, 8'hFF, 1'b0);
    run_to_idle(1'b1, 1'b0);
    @(negedge clk);
    drive_tick(ACT_READ, 8'hFF, 8'h00, 1'b1);
    run_to_idle(1'b0, 1'b1);

    // random transfers under several device addresses
    for (int p = 0; p < 3; p++) begin
      set_address(addr_plan[p]);
      if (p == 0) hold_pop = 1'b1;
      repeat (30) random_tick();
      run_to_idle(1'b1, 1'b0);
    end

    drain();
    repeat (10) @(negedge clk);
    $display("%0d ticks sent, %0d results compared", sent, checked);
    $display("%0d writes and %0d reads started over %0d address settings",
             writes, reads, settings);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ieba_pkg.sv
rtl/core/ieba_front.sv
rtl/core/ieba_seq.sv
rtl/core/ieba_out_fifo.sv
rtl/core/i2c_eeprom_byte_access_master_top.sv
bench/eeprom_bus_checker.sv
bench/tb_i2c_eeprom_byte_access_master_top.sv
